>>> hdl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/shm_pkg.sv
// types and constants of the selectable hash modulo block
`default_nettype none
package shm_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned DIV_STAGES = KEY_W;
  localparam int unsigned MIX_SHIFT = 16;

  localparam logic [KEY_W-1:0] MIX_MULT    = 32'h045d9f3b;
  localparam logic [KEY_W-1:0] GOLDEN_MULT = 32'h9E3779B9;

  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_MIX    = 2'd1;
  localparam logic [1:0] KIND_GOLDEN = 2'd2;

  localparam logic [1:0] REG_HASH_KIND = 2'd0;
  localparam logic [1:0] REG_MODULUS   = 2'd1;

  typedef logic [KEY_W-1:0] word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> hdl/shm_front.sv
// front end: three stage hash mixer feeding the queue
`default_nettype none
`include "assert_macros.svh"
module shm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire shm_pkg::word_t    in_key,
  input  wire logic [1:0]        kind,
  input  wire shm_pkg::q_status_t q_status,
  output logic                   push,
  output shm_pkg::word_t         push_data
);

  logic           v1_r, v2_r, v3_r;
  shm_pkg::word_t f1_r, f2_r, f3_r;
  shm_pkg::word_t a1, c1, p1, f1_nxt;
  shm_pkg::word_t b2, p2, f2_nxt, f3_nxt;
  logic           en;

  // whole front holds only when its last item cannot enter the queue
  assign en        = !(v3_r && q_status.full);
  assign in_stall  = !en;
  assign push      = v3_r && !q_status.full;
  assign push_data = f3_r;

  always_comb begin
    a1 = (kind == shm_pkg::KIND_MIX) ? (in_key ^ (in_key >> shm_pkg::MIX_SHIFT)) : in_key;
    c1 = (kind == shm_pkg::KIND_GOLDEN) ? shm_pkg::GOLDEN_MULT : shm_pkg::MIX_MULT;
    p1 = a1 * c1;
    f1_nxt = (kind == shm_pkg::KIND_MIX || kind == shm_pkg::KIND_GOLDEN) ? p1 : in_key;

    b2 = f1_r ^ (f1_r >> shm_pkg::MIX_SHIFT);
    p2 = b2 * shm_pkg::MIX_MULT;
    f2_nxt = (kind == shm_pkg::KIND_MIX) ? p2 : f1_r;

    f3_nxt = (kind == shm_pkg::KIND_MIX) ? (f2_r ^ (f2_r >> shm_pkg::MIX_SHIFT)) : f2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
    end
  end

  `ASSERT_CLK(a_stall_needs_item, in_stall |-> (v3_r && q_status.full), "front stalled without a blocked item")
  `ASSERT_NEVER(a_push_when_full, push && q_status.full, "front pushed into a full queue")

endmodule
`default_nettype wire

>>> hdl/shm_queue.sv
// short fifo between the hash front end and the divider back end
`default_nettype none
`include "assert_macros.svh"
module shm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire shm_pkg::word_t     push_data,
  input  wire logic               pop,
  output shm_pkg::word_t          pop_data,
  output shm_pkg::q_status_t      q_status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  shm_pkg::word_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_status.full  = (count_r == CW'(DEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_data       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  `ASSERT_CLK(a_count_up, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "queue count did not rise on push")
  `ASSERT_NEVER(a_pop_when_empty, pop && q_status.empty, "queue popped while empty")

endmodule
`default_nettype wire

>>> hdl/shm_back.sv
// back end: pipelined restoring remainder, one dividend bit per stage
`default_nettype none
`include "assert_macros.svh"
module shm_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire shm_pkg::q_status_t q_status,
  input  wire shm_pkg::word_t     pop_data,
  output logic                    pop,
  input  wire shm_pkg::word_t     modulus,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output shm_pkg::word_t          out_bucket
);

  localparam int unsigned N = shm_pkg::DIV_STAGES;

  logic [N-1:0]   v_r;
  shm_pkg::word_t rem_r [N];
  shm_pkg::word_t num_r [N];
  shm_pkg::word_t src_rem [N];
  shm_pkg::word_t src_num [N];
  shm_pkg::word_t rem_nxt [N];
  shm_pkg::word_t num_nxt [N];
  logic [shm_pkg::KEY_W:0] trial [N];
  logic           en;

  assign en         = !(v_r[N-1] && out_stall);
  assign pop        = en && !q_status.empty;
  assign out_valid  = v_r[N-1];
  assign out_bucket = rem_r[N-1];

  always_comb begin
    src_rem[0] = '0;
    src_num[0] = pop_data;
    for (int k = 1; k < N; k++) begin
      src_rem[k] = rem_r[k-1];
      src_num[k] = num_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      // shift in the next dividend bit, subtract when it fits
      trial[k]   = {src_rem[k], src_num[k][shm_pkg::KEY_W-1]};
      rem_nxt[k] = (trial[k] >= {1'b0, modulus}) ?
                   shm_pkg::KEY_W'(trial[k] - {1'b0, modulus}) :
                   shm_pkg::KEY_W'(trial[k]);
      num_nxt[k] = {src_num[k][shm_pkg::KEY_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
      end
    end
  end

  `ASSERT_CLK(a_bucket_range, out_valid |-> (out_bucket < modulus), "bucket not below modulus")
  `ASSERT_CLK(a_hold_on_stall, (out_valid && out_stall) |=> (out_valid && $stable(out_bucket)), "stalled result moved")

endmodule
`default_nettype wire

>>> hdl/selectable_hash_modulo_top.sv
// an accepted key passes the hash stages, the queue and the 32 divider stages before out_valid
// throughput: one key per cycle unless in_stall; hash and 32 remainder stages are fully pipelined
// a stalled output holds the back end; the 4 entry queue lets the front keep taking keys meanwhile
// reset (rst_n low, synchronous): pipelines and queue empty, hash_kind 0, modulus 1
// top level: configuration registers, hash front end, queue, remainder back end
`default_nettype none
module selectable_hash_modulo_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_key,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_bucket,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [1:0]         kind_r;
  shm_pkg::word_t     modulus_r;
  shm_pkg::q_status_t q_status;
  logic               push, pop;
  shm_pkg::word_t     push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= shm_pkg::KIND_PLAIN;
      modulus_r <= 32'd1;
    end else if (cfg_we) begin
      if (cfg_index == shm_pkg::REG_HASH_KIND) kind_r <= cfg_wdata[1:0];
      // a zero modulus is dropped so the divider never sees zero
      if (cfg_index == shm_pkg::REG_MODULUS && cfg_wdata != '0) modulus_r <= cfg_wdata;
    end
  end

  shm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_key    (in_key),
    .kind      (kind_r),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  shm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  shm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_data   (pop_data),
    .pop        (pop),
    .modulus    (modulus_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_bucket (out_bucket)
  );

endmodule
`default_nettype wire
